/* hdl/rcffh_pkg.sv */
package rcffh_pkg;

	localparam int HeapWords = 1024;
	localparam int AW = $clog2(HeapWords);
	localparam int PW = AW + 1;
	localparam int MaxFreeBlock = 257;
	localparam int CarveWords = 256;
	localparam int MaxBytes = 512;

	localparam logic [15:0] HF_FREE = 16'h8000;
	localparam logic [15:0] HF_HANDLE = 16'h4000;
	localparam logic [15:0] HF_SIZE = 16'h01FF;
	localparam logic [15:0] HF_REF = 16'h3E00;
	localparam logic [15:0] HF_REFONE = 16'h0200;

	typedef enum logic [2:0] {
		CMD_ALLOC = 3'd0,
		CMD_FREE = 3'd1,
		CMD_ADDREF = 3'd2,
		CMD_READREF = 3'd3,
		CMD_FIND = 3'd4,
		CMD_GETH = 3'd5
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_BIG = 3'd1,
		ST_NONE = 3'd2,
		ST_NULL = 3'd3,
		ST_SAT = 3'd4,
		ST_FREED = 3'd5
	} status_t;

endpackage

/* hdl/refcounted_first_fit_heap.sv */
// Alloc and find walk the header chain with one or two heap memory reads per block visited;
// a merge rewrites the header (and a split header past the cap) and the merged block is read again.
// One command is in work at a time; the result register frees the input side on handoff.
// After reset a carving pass writes the initial free headers, one per cycle
// (four headers for the default heap), before the first transaction is accepted.
module refcounted_first_fit_heap (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// cmd[2:0], size_bytes[12:3], handle[28:13], block_address[38:29], zero fill
	input  logic [39:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// status[2:0], result_address[12:3], result_value[28:13], zero fill
	output logic [31:0] m_tdata
);

	localparam int AW = rcffh_pkg::AW;
	localparam int PW = rcffh_pkg::PW;
	localparam logic [PW-1:0] HEAP_END = PW'(rcffh_pkg::HeapWords);
	localparam logic [PW-1:0] MAXF = PW'(rcffh_pkg::MaxFreeBlock);

	typedef enum logic [3:0] {
		S_CARVE, S_IDLE, S_RD, S_DEC, S_RD2, S_DEC2, S_WR2, S_WR3, S_DONE
	} state_t;

	logic [15:0] mem [rcffh_pkg::HeapWords];
	logic [15:0] rdata;
	logic        re, we;
	logic [AW-1:0] raddr, waddr;
	logic [15:0] wdata;

	// Heap memory, one read and one write port, registered read data.
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end

	state_t state_q, ret_q;
	logic [2:0]  cmd_q;
	logic [15:0] hnd_q;
	logic [PW-1:0] a_q, p_q, need_q, nx_q, left_q;
	logic [15:0] h_q, h2_q, pend_q;
	logic [PW-1:0] pend_a_q;
	logic        oob_q, pend_v_q;
	logic        out_v_q;
	logic [31:0] out_q;

	assign s_tready = (state_q == S_IDLE) && !out_v_q;
	assign m_tvalid = out_v_q;
	assign m_tdata = out_q;

	// Read data as the model sees it: out-of-heap addresses read zero.
	logic [15:0] rd_v;
	assign rd_v = oob_q ? 16'h0 : rdata;

	logic [PW-1:0] ws, nx, rem, ns, carve_s, left_m1;
	assign ws = PW'(rd_v[8:0]);
	assign nx = p_q + PW'(1) + ws;
	assign rem = ws - need_q;
	assign ns = PW'(h_q[8:0]) + PW'(1) + PW'(rd_v[8:0]);
	assign left_m1 = left_q - PW'(1);
	assign carve_s = (left_m1 > PW'(rcffh_pkg::CarveWords)) ?
		PW'(rcffh_pkg::CarveWords) : left_m1;

	// Handle word of the current block: its last data word.
	logic [PW-1:0] hwadd;
	assign hwadd = p_q + PW'(h_q[8:0]);

	function automatic logic [31:0] pack(input logic [2:0] st, input logic [PW-1:0] ad,
		input logic [15:0] v);
		pack = {3'b000, v, ad[9:0], st};
	endfunction

	// Memory port drive from the sequencer.
	always_comb begin
		re = 1'b0;
		raddr = '0;
		we = 1'b0;
		waddr = '0;
		wdata = '0;
		case (state_q)
			S_CARVE: begin
				we = 1'b1;
				waddr = p_q[AW-1:0];
				wdata = rcffh_pkg::HF_FREE | 16'(carve_s);
			end
			S_RD: begin
				re = 1'b1;
				raddr = p_q[AW-1:0];
			end
			S_RD2: begin
				re = 1'b1;
				raddr = (cmd_q == rcffh_pkg::CMD_ALLOC) ? nx_q[AW-1:0] : hwadd[AW-1:0];
			end
			S_WR2, S_WR3, S_DONE: begin
				we = pend_v_q && (pend_a_q < HEAP_END);
				waddr = pend_a_q[AW-1:0];
				wdata = pend_q;
			end
			default: ;
		endcase
	end

	// Command sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CARVE;
			ret_q <= S_IDLE;
			p_q <= '0;
			left_q <= HEAP_END;
			out_v_q <= 1'b0;
			pend_v_q <= 1'b0;
			oob_q <= 1'b0;
		end else begin
			if (out_v_q && m_tready) out_v_q <= 1'b0;
			case (state_q)
				S_CARVE: begin
					p_q <= p_q + PW'(1) + carve_s;
					left_q <= left_m1 - carve_s;
					if (left_m1 - carve_s == '0) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (s_tvalid && s_tready) begin
						cmd_q <= s_tdata[2:0];
						hnd_q <= s_tdata[28:13];
						a_q <= PW'(s_tdata[38:29]);
						need_q <= PW'(({1'b0, s_tdata[12:3]} + 11'd1) >> 1) +
							PW'(s_tdata[28:13] != 16'h0);
						case (s_tdata[2:0])
							rcffh_pkg::CMD_ALLOC: begin
								if (s_tdata[12:3] > 10'(rcffh_pkg::MaxBytes)) begin
									out_q <= pack(rcffh_pkg::ST_BIG, '0, '0);
									out_v_q <= 1'b1;
								end else begin
									p_q <= '0;
									state_q <= S_RD;
								end
							end
							rcffh_pkg::CMD_FIND: begin
								p_q <= '0;
								state_q <= S_RD;
							end
							rcffh_pkg::CMD_FREE, rcffh_pkg::CMD_ADDREF,
							rcffh_pkg::CMD_READREF, rcffh_pkg::CMD_GETH: begin
								if (s_tdata[38:29] == 10'd0 ||
									PW'(s_tdata[38:29]) > HEAP_END) begin
									out_q <= pack(rcffh_pkg::ST_NULL, '0, '0);
									out_v_q <= 1'b1;
								end else begin
									p_q <= PW'(s_tdata[38:29]) - PW'(1);
									state_q <= S_RD;
								end
							end
							default: begin
								out_q <= pack(rcffh_pkg::ST_NULL, '0, '0);
								out_v_q <= 1'b1;
							end
						endcase
					end
				end
				S_RD: begin
					oob_q <= 1'b0;
					if (p_q >= HEAP_END) begin
						// Walk has run off the heap end.
						out_q <= pack(rcffh_pkg::ST_NONE, '0, '0);
						out_v_q <= 1'b1;
						state_q <= S_DONE;
					end else state_q <= S_DEC;
				end
				S_DEC: begin
					h_q <= rd_v;
					nx_q <= nx;
					case (cmd_q)
						rcffh_pkg::CMD_ALLOC: begin
							if (rd_v[15] && ws >= need_q) begin
								pend_v_q <= (rem != '0);
								pend_a_q <= p_q + PW'(1) + need_q;
								pend_q <= rcffh_pkg::HF_FREE | 16'(rem - PW'(1));
								h2_q <= 16'(need_q) | rcffh_pkg::HF_REFONE |
									((hnd_q != 16'h0) ? rcffh_pkg::HF_HANDLE : 16'h0);
								state_q <= S_WR2;
								ret_q <= S_IDLE;
							end else if (rd_v[15] && ws < MAXF) begin
								oob_q <= (nx >= HEAP_END);
								state_q <= S_RD2;
							end else begin
								p_q <= nx;
								state_q <= S_RD;
							end
						end
						rcffh_pkg::CMD_FIND: begin
							if (rd_v[14] && !rd_v[15]) begin
								oob_q <= ((p_q + ws) >= HEAP_END);
								state_q <= S_RD2;
							end else begin
								p_q <= nx;
								state_q <= S_RD;
							end
						end
						rcffh_pkg::CMD_FREE: begin
							if (rd_v[15]) begin
								out_q <= pack(rcffh_pkg::ST_FREED, '0, '0);
								out_v_q <= 1'b1;
								state_q <= S_DONE;
							end else begin
								h2_q <= ((rd_v & rcffh_pkg::HF_REF) != 0) ?
									rd_v - rcffh_pkg::HF_REFONE : rd_v;
								state_q <= S_WR3;
							end
						end
						rcffh_pkg::CMD_ADDREF: begin
							if ((rd_v & rcffh_pkg::HF_REF) == rcffh_pkg::HF_REF) begin
								out_q <= pack(rcffh_pkg::ST_SAT, '0, '0);
								out_v_q <= 1'b1;
								state_q <= S_DONE;
							end else begin
								h2_q <= rd_v + rcffh_pkg::HF_REFONE;
								state_q <= S_WR3;
							end
						end
						rcffh_pkg::CMD_READREF: begin
							out_q <= pack(rcffh_pkg::ST_OK, '0, rd_v & rcffh_pkg::HF_REF);
							out_v_q <= 1'b1;
							state_q <= S_DONE;
						end
						default: begin
							if (rd_v[14]) begin
								oob_q <= ((p_q + ws) >= HEAP_END);
								state_q <= S_RD2;
							end else begin
								out_q <= pack(rcffh_pkg::ST_OK, '0, '0);
								out_v_q <= 1'b1;
								state_q <= S_DONE;
							end
						end
					endcase
				end
				S_RD2: state_q <= S_DEC2;
				S_DEC2: begin
					case (cmd_q)
						rcffh_pkg::CMD_ALLOC: begin
							if (rd_v[15]) begin
								// Merge the free neighbor, splitting past the cap.
								pend_v_q <= (ns > MAXF);
								pend_a_q <= p_q + PW'(1) + MAXF;
								pend_q <= rcffh_pkg::HF_FREE |
									(16'(ns - MAXF - PW'(1)) & rcffh_pkg::HF_SIZE);
								h2_q <= rcffh_pkg::HF_FREE |
									(16'((ns > MAXF) ? MAXF : ns) & rcffh_pkg::HF_SIZE);
								ret_q <= S_RD;
								state_q <= S_WR2;
							end else begin
								p_q <= nx_q;
								state_q <= S_RD;
							end
						end
						rcffh_pkg::CMD_FIND: begin
							if (rd_v == hnd_q) begin
								out_q <= pack(rcffh_pkg::ST_OK, p_q + PW'(1), '0);
								out_v_q <= 1'b1;
								state_q <= S_DONE;
							end else begin
								p_q <= nx_q;
								state_q <= S_RD;
							end
						end
						default: begin
							out_q <= pack(rcffh_pkg::ST_OK, '0, rd_v);
							out_v_q <= 1'b1;
							state_q <= S_DONE;
						end
					endcase
				end
				S_WR2: begin
					// Split or overflow header, then the handle word for alloc.
					if (cmd_q == rcffh_pkg::CMD_ALLOC && ret_q == S_IDLE) begin
						pend_v_q <= (hnd_q != 16'h0);
						pend_a_q <= p_q + need_q;
						pend_q <= hnd_q;
					end else pend_v_q <= 1'b0;
					state_q <= S_WR3;
				end
				S_WR3: begin
					pend_v_q <= 1'b1;
					pend_a_q <= p_q;
					if (cmd_q == rcffh_pkg::CMD_FREE)
						pend_q <= ((h2_q & rcffh_pkg::HF_REF) == 0) ?
							(h2_q | rcffh_pkg::HF_FREE) : h2_q;
					else pend_q <= h2_q;
					state_q <= S_DONE;
					if (pend_v_q && (cmd_q == rcffh_pkg::CMD_ALLOC)) begin
						// handle word goes out this cycle; header next
					end
				end
				S_DONE: begin
					if (pend_v_q) begin
						pend_v_q <= 1'b0;
						case (cmd_q)
							rcffh_pkg::CMD_ALLOC: begin
								if (ret_q == S_RD) state_q <= S_RD;
								else begin
									out_q <= pack(rcffh_pkg::ST_OK, p_q + PW'(1), '0);
									out_v_q <= 1'b1;
									state_q <= S_IDLE;
								end
							end
							rcffh_pkg::CMD_FREE: begin
								out_q <= pack(rcffh_pkg::ST_OK, '0, pend_q & rcffh_pkg::HF_REF);
								out_v_q <= 1'b1;
								state_q <= S_IDLE;
							end
							default: begin
								out_q <= pack(rcffh_pkg::ST_OK, a_q, pend_q & rcffh_pkg::HF_REF);
								out_v_q <= 1'b1;
								state_q <= S_IDLE;
							end
						endcase
					end else state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* bench/refcounted_first_fit_heap_tb.sv */
module refcounted_first_fit_heap_tb;

	// Command codes outside the defined set; the block must reject them.
	localparam logic [2:0] CMD_BAD6 = 3'd6;
	localparam logic [2:0] CMD_BAD7 = 3'd7;
	localparam int RandomCount = 1500;
	localparam longint CycleLimit = 100000000;
	localparam int HW = rcffh_pkg::HeapWords;

	// Mirror of the heap words plus the outcome of every accepted command.
	class heap_scoreboard;
		logic [15:0] words [rcffh_pkg::HeapWords];
		bit written [rcffh_pkg::HeapWords];
		logic [31:0] due [$];
		int mismatches;
		logic [9:0] last_addr;

		function new();
			int p;
			int left;
			int s;
			mismatches = 0;
			last_addr = 0;
			for (int i = 0; i < HW; i++) begin
				words[i] = 16'h0;
				written[i] = 0;
			end
			// Carve the heap into free blocks of 256 words, the last one takes the rest.
			p = 0;
			left = HW;
			while (left > 0) begin
				left--;
				s = (left > rcffh_pkg::CarveWords) ? rcffh_pkg::CarveWords : left;
				wr(p, rcffh_pkg::HF_FREE | 16'(s));
				p += 1 + s;
				left -= s;
			end
		endfunction

		function logic [15:0] rd(int i);
			return (i < HW) ? words[i] : 16'h0;
		endfunction

		function void wr(int i, logic [15:0] v);
			if (i < HW) begin
				words[i] = v;
				written[i] = 1;
			end
		endfunction

		// First-fit allocation; merges free neighbors while walking.
		function rcffh_pkg::status_t alloc_block(int bytes, logic [15:0] hnd, output int addr);
			int need;
			int p;
			int ws;
			int nx;
			int rem;
			int ns;
			logic [15:0] h;
			logic [15:0] nh;
			addr = 0;
			if (bytes > rcffh_pkg::MaxBytes) return rcffh_pkg::ST_BIG;
			need = (bytes + 1) >> 1;
			if (hnd != 0) need++;
			p = 0;
			while (p < HW) begin
				h = rd(p);
				ws = int'(h & rcffh_pkg::HF_SIZE);
				nx = p + 1 + ws;
				if ((h & rcffh_pkg::HF_FREE) != 0 && ws >= need) begin
					rem = ws - need;
					nh = 16'(need) | rcffh_pkg::HF_REFONE;
					if (rem != 0) wr(p + 1 + need, rcffh_pkg::HF_FREE | 16'(rem - 1));
					if (hnd != 0) begin
						nh |= rcffh_pkg::HF_HANDLE;
						wr(p + need, hnd);
					end
					wr(p, nh);
					addr = p + 1;
					return rcffh_pkg::ST_OK;
				end else if ((h & rcffh_pkg::HF_FREE) != 0 && ws < rcffh_pkg::MaxFreeBlock &&
						(rd(nx) & rcffh_pkg::HF_FREE) != 0) begin
					ns = ws + 1 + int'(rd(nx) & rcffh_pkg::HF_SIZE);
					if (ns > rcffh_pkg::MaxFreeBlock) begin
						wr(p + 1 + rcffh_pkg::MaxFreeBlock, rcffh_pkg::HF_FREE |
							(16'(ns - rcffh_pkg::MaxFreeBlock - 1) & rcffh_pkg::HF_SIZE));
						ns = rcffh_pkg::MaxFreeBlock;
					end
					wr(p, rcffh_pkg::HF_FREE | (16'(ns) & rcffh_pkg::HF_SIZE));
				end else begin
					p = nx;
				end
			end
			return rcffh_pkg::ST_NONE;
		endfunction

		// Work out the result of one accepted command and queue it.
		function void note_input(logic [39:0] d);
			logic [2:0] cmd;
			int bytes;
			logic [15:0] hnd;
			int a;
			int hi;
			int p;
			int ws;
			int addr;
			logic [15:0] h;
			rcffh_pkg::status_t st;
			logic [15:0] val;
			cmd = d[2:0];
			bytes = int'(d[12:3]);
			hnd = d[28:13];
			a = int'(d[38:29]);
			st = rcffh_pkg::ST_OK;
			addr = 0;
			val = 0;
			if (cmd == rcffh_pkg::CMD_ALLOC) begin
				st = alloc_block(bytes, hnd, addr);
				if (st == rcffh_pkg::ST_OK) last_addr = 10'(addr);
			end else if (cmd == rcffh_pkg::CMD_FIND) begin
				st = rcffh_pkg::ST_NONE;
				p = 0;
				while (p < HW) begin
					h = rd(p);
					ws = int'(h & rcffh_pkg::HF_SIZE);
					if ((h & rcffh_pkg::HF_HANDLE) != 0 && (h & rcffh_pkg::HF_FREE) == 0 &&
							rd(p + ws) == hnd) begin
						st = rcffh_pkg::ST_OK;
						addr = p + 1;
						break;
					end
					p += 1 + ws;
				end
			end else if (cmd == CMD_BAD6 || cmd == CMD_BAD7 || a == 0 || a - 1 >= HW) begin
				st = rcffh_pkg::ST_NULL;
			end else begin
				hi = a - 1;
				h = rd(hi);
				case (cmd)
					rcffh_pkg::CMD_FREE: begin
						if ((h & rcffh_pkg::HF_FREE) != 0) begin
							st = rcffh_pkg::ST_FREED;
						end else begin
							if ((h & rcffh_pkg::HF_REF) != 0) h -= rcffh_pkg::HF_REFONE;
							if ((h & rcffh_pkg::HF_REF) == 0) h |= rcffh_pkg::HF_FREE;
							wr(hi, h);
							val = h & rcffh_pkg::HF_REF;
						end
					end
					rcffh_pkg::CMD_ADDREF: begin
						if ((h & rcffh_pkg::HF_REF) == rcffh_pkg::HF_REF) begin
							st = rcffh_pkg::ST_SAT;
						end else begin
							h += rcffh_pkg::HF_REFONE;
							wr(hi, h);
							addr = a;
							val = h & rcffh_pkg::HF_REF;
						end
					end
					rcffh_pkg::CMD_READREF: val = h & rcffh_pkg::HF_REF;
					default: val = ((h & rcffh_pkg::HF_HANDLE) != 0) ?
						rd(hi + int'(h & rcffh_pkg::HF_SIZE)) : 16'h0;
				endcase
			end
			due.push_back({3'b0, val, 10'(addr), 3'(st)});
		endfunction

		function void complain(string what, logic [31:0] exp_r, logic [31:0] got);
			mismatches++;
			if (mismatches <= 10)
				$display({"mismatch (%s): expected status %0d addr %0d value %h, ",
					"got status %0d addr %0d value %h"},
					what, exp_r[2:0], exp_r[12:3], exp_r[28:13],
					got[2:0], got[12:3], got[28:13]);
		endfunction

		// Compare one result transaction with the oldest outstanding expectation.
		function void check_result(logic [31:0] got);
			logic [31:0] exp_r;
			if (due.size() == 0) begin
				complain("unexpected result", 32'h0, got);
				return;
			end
			exp_r = due.pop_front();
			if (got[2:0] !== exp_r[2:0]) complain("status", exp_r, got);
			else if (got[12:3] !== exp_r[12:3]) complain("address", exp_r, got);
			else if (got[28:13] !== exp_r[28:13]) complain("value", exp_r, got);
			else if (got[31:29] !== 3'b0) complain("fill", exp_r, got);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [39:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [31:0] m_tdata;
	bit calm;
	longint cycles;
	heap_scoreboard sb;

	refcounted_first_fit_heap DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		clk = 0;
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		m_tready = 0;
		calm = 0;
		cycles = 0;
		sb = new();
	end

	always #2 clk = ~clk;

	// Result side: random backpressure, none during the calm stretch.
	always @(negedge clk) begin
		m_tready <= calm || ($urandom_range(0, 99) >= 10);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata);
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("refcounted_first_fit_heap_tb: FAIL");
			$finish;
		end
	end

	// Drive one command transaction and wait for its acceptance.
	task automatic send(logic [2:0] cmd, int bytes, logic [15:0] hnd, int a);
		@(negedge clk);
		while (!calm && $urandom_range(0, 99) < 10) begin
			s_tvalid <= 0;
			@(negedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {1'b0, 10'(a), hnd, 10'(bytes), cmd};
		do @(posedge clk); while (!s_tready);
		sb.note_input(s_tdata);
	endtask

	// Pick a block address that only touches words written since reset.
	function automatic int pick_addr(logic [2:0] cmd);
		int heads [$];
		int p;
		int a;
		int hi;
		logic [15:0] h;
		if ($urandom_range(0, 99) < 8) return 0;
		if ($urandom_range(0, 99) < 20) begin
			repeat (20) begin
				a = $urandom_range(1, HW - 1);
				hi = a - 1;
				if (sb.written[hi]) begin
					h = sb.words[hi];
					if (cmd != rcffh_pkg::CMD_GETH || (h & rcffh_pkg::HF_HANDLE) == 0 ||
							hi + int'(h & rcffh_pkg::HF_SIZE) >= HW ||
							sb.written[hi + int'(h & rcffh_pkg::HF_SIZE)])
						return a;
				end
			end
		end
		p = 0;
		while (p < HW) begin
			heads.push_back(p);
			p += 1 + int'(sb.rd(p) & rcffh_pkg::HF_SIZE);
		end
		return heads[$urandom_range(0, heads.size() - 1)] + 1;
	endfunction

	// Handle of a live block most of the time, otherwise anything.
	function automatic logic [15:0] pick_handle();
		logic [15:0] live [$];
		logic [15:0] h;
		int p;
		p = 0;
		while (p < HW) begin
			h = sb.rd(p);
			if ((h & rcffh_pkg::HF_HANDLE) != 0 && (h & rcffh_pkg::HF_FREE) == 0)
				live.push_back(sb.rd(p + int'(h & rcffh_pkg::HF_SIZE)));
			p += 1 + int'(h & rcffh_pkg::HF_SIZE);
		end
		if (live.size() > 0 && $urandom_range(0, 99) < 60)
			return live[$urandom_range(0, live.size() - 1)];
		return 16'($urandom);
	endfunction

	initial begin
		int k;
		int bytes;
		int a;
		logic [2:0] cmd;
		logic [15:0] hnd;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		// Directed: size extremes, every command, the special cases.
		send(rcffh_pkg::CMD_ALLOC, 0, 16'h0, 0);
		send(rcffh_pkg::CMD_ALLOC, 512, 16'hFFFF, 0);
		a = sb.last_addr;
		send(rcffh_pkg::CMD_ALLOC, 513, 16'h1, 0);
		send(rcffh_pkg::CMD_ALLOC, 1023, 16'h0, 0);
		send(rcffh_pkg::CMD_FIND, 0, 16'hFFFF, 0);
		send(rcffh_pkg::CMD_FIND, 0, 16'h1234, 0);
		send(rcffh_pkg::CMD_GETH, 0, 16'h0, a);
		send(rcffh_pkg::CMD_GETH, 0, 16'h0, 1);
		send(rcffh_pkg::CMD_READREF, 0, 16'h0, a);
		send(rcffh_pkg::CMD_ADDREF, 0, 16'h0, 0);
		send(rcffh_pkg::CMD_FREE, 0, 16'h0, 0);
		send(CMD_BAD6, 0, 16'h0, a);
		send(CMD_BAD7, 1023, 16'hFFFF, 1023);
		// Count saturation on a one-word handle block.
		send(rcffh_pkg::CMD_ALLOC, 0, 16'h5A5A, 0);
		k = sb.last_addr;
		for (int i = 0; i < 31; i++) send(rcffh_pkg::CMD_ADDREF, 0, 16'h0, k);
		send(rcffh_pkg::CMD_READREF, 0, 16'h0, k);
		send(rcffh_pkg::CMD_GETH, 0, 16'h0, k);
		send(rcffh_pkg::CMD_FREE, 0, 16'h0, a);
		send(rcffh_pkg::CMD_FREE, 0, 16'h0, a);
		send(rcffh_pkg::CMD_FREE, 0, 16'h0, 1);
		send(rcffh_pkg::CMD_ALLOC, 1, 16'h8001, 0);

		// Random mix, mostly allocations and frees with random content.
		for (int i = 0; i < RandomCount; i++) begin
			calm = (i >= 500 && i < 800);
			k = $urandom_range(0, 99);
			bytes = 0;
			hnd = 0;
			a = 0;
			if (k < 35) begin
				cmd = rcffh_pkg::CMD_ALLOC;
				k = $urandom_range(0, 99);
				bytes = (k < 80) ? $urandom_range(0, 40) :
					(k < 95) ? $urandom_range(0, 512) : $urandom_range(0, 1023);
				hnd = ($urandom_range(0, 1) == 0) ? 16'h0 : 16'($urandom);
			end else if (k < 60) begin
				cmd = rcffh_pkg::CMD_FREE;
			end else if (k < 72) begin
				cmd = rcffh_pkg::CMD_ADDREF;
			end else if (k < 80) begin
				cmd = rcffh_pkg::CMD_READREF;
			end else if (k < 88) begin
				cmd = rcffh_pkg::CMD_FIND;
				hnd = pick_handle();
			end else if (k < 96) begin
				cmd = rcffh_pkg::CMD_GETH;
			end else begin
				cmd = ($urandom_range(0, 1) == 0) ? CMD_BAD6 : CMD_BAD7;
				bytes = $urandom_range(0, 1023);
				hnd = 16'($urandom);
				a = $urandom_range(0, 1023);
			end
			if (cmd != rcffh_pkg::CMD_ALLOC && cmd != rcffh_pkg::CMD_FIND &&
					cmd != CMD_BAD6 && cmd != CMD_BAD7)
				a = pick_addr(cmd);
			send(cmd, bytes, hnd, a);
		end
		calm = 0;
		@(negedge clk);
		s_tvalid <= 0;

		while (sb.due.size() > 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.mismatches == 0) begin
			$display("refcounted_first_fit_heap_tb: PASS");
		end else begin
			$display("refcounted_first_fit_heap_tb: FAIL");
		end
		$finish;
	end

endmodule
